[rtl/core/cdv_pkg.sv]
// cdv_pkg: shared constants, codes and controller/datapath structs
// for the covering design verifier; no dependencies
package cdv_pkg;

	localparam int MAX_BALLS  = 54;
	localparam int MAX_TICKET = 7;
	localparam int BALL_W     = 6;
	localparam int CNT_W      = 28;
	localparam int ADDR_W     = 3 * BALL_W;
	localparam int POS_W      = 3;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	// input commands
	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_VERIFY = 1'b1;

	// result kinds
	localparam logic [1:0] KIND_ACK    = 2'd0;
	localparam logic [1:0] KIND_REPORT = 2'd1;
	localparam logic [1:0] KIND_FINAL  = 2'd2;

	// load status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BAD       = 2'd1;
	localparam logic [1:0] ST_DUP       = 2'd2;
	localparam logic [1:0] ST_REDUNDANT = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MATCH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TICKET = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BALLS  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 2'd3;

	typedef logic [BALL_W-1:0] ball_t;

	typedef struct packed {
		logic       latch;
		logic       clr_step;
		logic       sort_step;
		logic       mark;
		logic       scan;
		logic       walk_init;
		logic       walk_step;
		logic       emit;
		logic [1:0] emit_kind;
	} cdv_cmd_t;

	typedef struct packed {
		logic       clr_done;
		logic [1:0] err;
		logic       sort_done;
		logic       sub_last;
		logic       scan_stop;
		logic       report_due;
		logic       walk_last;
		logic       walk_empty;
		logic       out_free;
	} cdv_stat_t;

endpackage

[rtl/core/cdv_if.sv]
// cdv_in_if / cdv_out_if: valid-ready channels for items and results
// depends on cdv_pkg
interface cdv_in_if;
	import cdv_pkg::*;
	logic  valid;
	logic  ready;
	logic  cmd;
	ball_t ball_1;
	ball_t ball_2;
	ball_t ball_3;
	ball_t ball_4;
	ball_t ball_5;
	ball_t ball_6;
	ball_t ball_7;
	modport source (output valid, cmd, ball_1, ball_2, ball_3, ball_4, ball_5, ball_6,
		ball_7, input ready);
	modport sink (input valid, cmd, ball_1, ball_2, ball_3, ball_4, ball_5, ball_6,
		ball_7, output ready);
endinterface

interface cdv_out_if;
	import cdv_pkg::*;
	logic             valid;
	logic             ready;
	logic [1:0]       kind;
	logic [1:0]       status;
	ball_t            out_ball_1;
	ball_t            out_ball_2;
	ball_t            out_ball_3;
	ball_t            out_ball_4;
	ball_t            out_ball_5;
	ball_t            out_ball_6;
	ball_t            out_ball_7;
	logic [CNT_W-1:0] losing_count;
	logic [CNT_W-1:0] winning_count;
	logic             last;
	modport source (output valid, kind, status, out_ball_1, out_ball_2, out_ball_3,
		out_ball_4, out_ball_5, out_ball_6, out_ball_7, losing_count, winning_count,
		last, input ready);
	modport sink (input valid, kind, status, out_ball_1, out_ball_2, out_ball_3,
		out_ball_4, out_ball_5, out_ball_6, out_ball_7, losing_count, winning_count,
		last, output ready);
endinterface

[rtl/core/cdv_ctrl.sv]
// cdv_ctrl: sequencing state machine for load, verify and clearing pass
// depends on cdv_pkg
module cdv_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_cmd,
	output logic              in_ready,
	input  cdv_pkg::cdv_stat_t stat,
	output cdv_pkg::cdv_cmd_t  cmd
);
	import cdv_pkg::*;

	typedef enum logic [12:0] {
		S_CLEAR  = 13'b0000000000001,
		S_IDLE   = 13'b0000000000010,
		S_CHECK  = 13'b0000000000100,
		S_SORT   = 13'b0000000001000,
		S_MARK   = 13'b0000000010000,
		S_MTAIL  = 13'b0000000100000,
		S_ACK    = 13'b0000001000000,
		S_VINIT  = 13'b0000010000000,
		S_SCAN   = 13'b0000100000000,
		S_DECIDE = 13'b0001000000000,
		S_REPORT = 13'b0010000000000,
		S_STEP   = 13'b0100000000000,
		S_FINAL  = 13'b1000000000000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = (in_cmd == CMD_VERIFY) ? S_VINIT : S_CHECK;
				end
			end
			S_CHECK: begin
				state_d = (stat.err != ST_OK) ? S_ACK : S_SORT;
			end
			S_SORT: begin
				cmd.sort_step = 1'b1;
				if (stat.sort_done) state_d = S_MARK;
			end
			S_MARK: begin
				cmd.mark = 1'b1;
				if (stat.sub_last) state_d = S_MTAIL;
			end
			S_MTAIL: state_d = S_ACK;
			S_ACK: begin
				if (stat.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = KIND_ACK;
					state_d       = S_IDLE;
				end
			end
			S_VINIT: begin
				cmd.walk_init = 1'b1;
				state_d       = stat.walk_empty ? S_FINAL : S_SCAN;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.scan_stop) state_d = S_DECIDE;
			end
			S_DECIDE: state_d = stat.report_due ? S_REPORT : S_STEP;
			S_REPORT: begin
				if (stat.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = KIND_REPORT;
					state_d       = S_STEP;
				end
			end
			S_STEP: begin
				if (stat.walk_last) begin
					state_d = S_FINAL;
				end else begin
					cmd.walk_step = 1'b1;
					state_d       = S_SCAN;
				end
			end
			S_FINAL: begin
				if (stat.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = KIND_FINAL;
					state_d       = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[rtl/core/cdv_dp.sv]
// cdv_dp: configuration, ticket sorter, subset stepper, flag memory,
// walk register, totals and output register; depends on cdv_pkg
module cdv_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [cdv_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cdv_pkg::BALL_W-1:0]   cfg_data,
	input  logic                         in_cmd,
	input  cdv_pkg::ball_t               in_ball [cdv_pkg::MAX_TICKET],
	input  cdv_pkg::cdv_cmd_t            cmd,
	output cdv_pkg::cdv_stat_t           stat,
	input  logic                         out_ready,
	output logic                         out_valid,
	output logic [1:0]                   out_kind,
	output logic [1:0]                   out_status,
	output cdv_pkg::ball_t               out_ball [cdv_pkg::MAX_TICKET],
	output logic [cdv_pkg::CNT_W-1:0]    out_losing,
	output logic [cdv_pkg::CNT_W-1:0]    out_winning,
	output logic                         out_last
);
	import cdv_pkg::*;

	// configuration
	logic [1:0]        match_q;
	logic [2:0]        ticket_q;
	logic [BALL_W-1:0] balls_q;
	logic [BALL_W-1:0] limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q  <= 2'd3;
			ticket_q <= 3'd6;
			balls_q  <= 6'd45;
			limit_q  <= 6'd10;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MATCH:  match_q  <= cfg_data[1:0];
				REG_TICKET: ticket_q <= cfg_data[2:0];
				REG_BALLS:  balls_q  <= cfg_data;
				REG_LIMIT:  limit_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [1:0]        eff_m;
	logic [POS_W-1:0]  eff_t;
	logic [BALL_W-1:0] eff_n;
	logic              m3;

	assign eff_m = (match_q < 2'd2) ? 2'd2 : match_q;
	assign m3    = (eff_m == 2'd3);
	assign eff_t = (ticket_q < {1'b0, eff_m}) ? {1'b0, eff_m} : ticket_q;
	assign eff_n = (balls_q > BALL_W'(MAX_BALLS)) ? BALL_W'(MAX_BALLS) : balls_q;

	// ticket register and number check
	logic             cmd_q;
	ball_t            ball_q [MAX_TICKET];
	logic [POS_W-1:0] sort_cnt_q;
	logic [1:0]       err;

	always_comb begin
		logic dup;
		err = ST_OK;
		dup = 1'b0;
		for (int p = 0; p < MAX_TICKET; p++) begin
			if (err == ST_OK && POS_W'(p) < eff_t) begin
				dup = 1'b0;
				for (int q = 0; q < MAX_TICKET; q++) begin
					if (q < p && ball_q[q] == ball_q[p]) dup = 1'b1;
				end
				if (ball_q[p] == '0 || ball_q[p] > eff_n) err = ST_BAD;
				else if (dup) err = ST_DUP;
			end
		end
	end

	// subset stepper over positions
	logic [POS_W-1:0] si_q, sj_q, sk_q;
	logic             sub_last;
	logic             issued_all_q;

	assign sub_last = m3 ? (si_q == eff_t - 3'd3 && sj_q == eff_t - 3'd2 &&
		sk_q == eff_t - 3'd1) : (si_q == eff_t - 3'd2 && sj_q == eff_t - 3'd1);

	// walk positions and pivot search
	ball_t            walk_q [MAX_TICKET];
	logic [POS_W-1:0] pivot;
	logic             found;
	ball_t            base;

	always_comb begin
		logic [BALL_W:0] lim;
		pivot = '0;
		found = 1'b0;
		lim   = '0;
		for (int p = 0; p < MAX_TICKET; p++) begin
			lim = (BALL_W+1)'(eff_n) - (BALL_W+1)'(eff_t) + (BALL_W+1)'(p) + 7'd1;
			if (POS_W'(p) < eff_t && {1'b0, walk_q[p]} < lim) begin
				pivot = POS_W'(p);
				found = 1'b1;
			end
		end
	end
	assign base = walk_q[pivot] + 6'd1;

	// flag memory address
	ball_t             vals [MAX_TICKET];
	logic [ADDR_W-1:0] addr;
	logic [ADDR_W-1:0] clr_cnt_q;
	logic              issue;
	logic              mem_we;
	logic              rdata_s1;
	logic              rd_vld_s1;
	logic              last_s1;
	logic              hit;
	logic              fresh_q;

	always_comb begin
		for (int p = 0; p < MAX_TICKET; p++) vals[p] = cmd_q ? walk_q[p] : ball_q[p];
	end

	assign addr   = cmd.clr_step ? clr_cnt_q :
		{vals[si_q], vals[sj_q], (m3 ? vals[sk_q] : ball_t'(0))};
	assign issue  = cmd.mark | (cmd.scan & ~issued_all_q);
	assign mem_we = cmd.clr_step | cmd.mark;
	assign hit    = rd_vld_s1 & rdata_s1;

	logic mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (mem_we) mem[addr] <= cmd.mark;
		rdata_s1 <= mem[addr];
	end

	// losing and winning totals
	logic [CNT_W-1:0] losing_q, winning_q;
	logic             lose_flag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q    <= '0;
			cmd_q        <= CMD_LOAD;
			sort_cnt_q   <= '0;
			si_q         <= 3'd0;
			sj_q         <= 3'd1;
			sk_q         <= 3'd2;
			issued_all_q <= 1'b0;
			rd_vld_s1    <= 1'b0;
			last_s1      <= 1'b0;
			fresh_q      <= 1'b0;
			losing_q     <= '0;
			winning_q    <= '0;
			lose_flag_q  <= 1'b0;
			out_valid    <= 1'b0;
		end else begin
			if (cmd.clr_step) clr_cnt_q <= clr_cnt_q + 1'b1;
			if (cmd.sort_step) sort_cnt_q <= sort_cnt_q + 3'd1;

			// no read is issued while latching or restarting a walk step
			rd_vld_s1 <= issue;
			last_s1   <= sub_last;
			if (rd_vld_s1 && !rdata_s1) fresh_q <= 1'b1;

			if (cmd.latch || cmd.walk_init || cmd.walk_step) begin
				si_q         <= 3'd0;
				sj_q         <= 3'd1;
				sk_q         <= 3'd2;
				issued_all_q <= 1'b0;
			end else if (issue) begin
				if (sub_last) begin
					issued_all_q <= 1'b1;
				end else if (m3 && sk_q < eff_t - 3'd1) begin
					sk_q <= sk_q + 3'd1;
				end else if (sj_q < eff_t - (m3 ? 3'd2 : 3'd1)) begin
					sj_q <= sj_q + 3'd1;
					sk_q <= sj_q + 3'd2;
				end else begin
					si_q <= si_q + 3'd1;
					sj_q <= si_q + 3'd2;
					sk_q <= si_q + 3'd3;
				end
			end

			if (cmd.latch) begin
				cmd_q      <= in_cmd;
				sort_cnt_q <= '0;
				fresh_q    <= 1'b0;
			end

			if (cmd.walk_init) begin
				losing_q    <= '0;
				winning_q   <= '0;
				lose_flag_q <= 1'b0;
			end else if (cmd.scan && (hit || (rd_vld_s1 && last_s1))) begin
				lose_flag_q <= ~hit;
				if (hit) winning_q <= (winning_q == CNT_MAX) ? CNT_MAX : winning_q + 1'b1;
				else losing_q <= (losing_q == CNT_MAX) ? CNT_MAX : losing_q + 1'b1;
			end

			if (cmd.emit) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end

	// ticket and walk payload registers
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			for (int p = 0; p < MAX_TICKET; p++)
				ball_q[p] <= (POS_W'(p) < eff_t) ? in_ball[p] : ball_t'(63);
		end else if (cmd.sort_step) begin
			// odd-even transposition pass
			for (int p = 0; p < MAX_TICKET - 1; p++) begin
				if ((p % 2) == int'(sort_cnt_q[0]) && ball_q[p] > ball_q[p+1]) begin
					ball_q[p]   <= ball_q[p+1];
					ball_q[p+1] <= ball_q[p];
				end
			end
		end
		if (cmd.walk_init) begin
			for (int p = 0; p < MAX_TICKET; p++)
				walk_q[p] <= (POS_W'(p) < eff_t) ? BALL_W'(p + 1) : ball_t'(0);
		end else if (cmd.walk_step) begin
			for (int p = 0; p < MAX_TICKET; p++)
				if (POS_W'(p) >= pivot && POS_W'(p) < eff_t)
					walk_q[p] <= base + (BALL_W'(p) - BALL_W'(pivot));
		end
		if (cmd.emit) begin
			out_kind    <= cmd.emit_kind;
			out_status  <= (cmd.emit_kind != KIND_ACK) ? ST_OK :
				(err != ST_OK) ? err : (fresh_q ? ST_OK : ST_REDUNDANT);
			for (int p = 0; p < MAX_TICKET; p++)
				out_ball[p] <= (cmd.emit_kind == KIND_REPORT) ? walk_q[p] : ball_t'(0);
			out_losing  <= (cmd.emit_kind == KIND_ACK) ? '0 : losing_q;
			out_winning <= (cmd.emit_kind == KIND_FINAL) ? winning_q : '0;
			out_last    <= (cmd.emit_kind != KIND_REPORT);
		end
	end

	assign stat.clr_done   = (clr_cnt_q == {ADDR_W{1'b1}});
	assign stat.err        = err;
	assign stat.sort_done  = (sort_cnt_q == POS_W'(MAX_TICKET - 1));
	assign stat.sub_last   = sub_last;
	assign stat.scan_stop  = hit | (rd_vld_s1 & last_s1);
	assign stat.report_due = lose_flag_q && (losing_q <= CNT_W'(limit_q));
	assign stat.walk_last  = ~found;
	assign stat.walk_empty = ({3'b000, eff_t} > eff_n);
	assign stat.out_free   = ~out_valid | out_ready;

endmodule

[rtl/core/covering_design_verifier_top.sv]
// load: each item is checked, then sorted and marked unless bad, then acknowledged; one at a time
// verify: each walked ticket is scanned subset by subset until a hit or its last subset,
// reported if due, then stepped; the single flag memory port reads one flag per cycle;
// results leave through an output register
// reset: all control clears at once, then a clearing pass writes the 262144-entry flag
// memory one entry a cycle; no item is taken until it ends (config writes still taken)
// top level: joins controller, datapath, channels and configuration port; depends on
// cdv_pkg, cdv_if, cdv_ctrl, cdv_dp
module covering_design_verifier_top (
	input  logic                          clk,
	input  logic                          arst_n,
	cdv_in_if.sink                        in_ch,
	cdv_out_if.source                     out_ch,
	input  logic                          cfg_we,
	input  logic [cdv_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cdv_pkg::BALL_W-1:0]    cfg_data
);
	import cdv_pkg::*;

	// command and status between controller and datapath
	cdv_cmd_t  cmd;
	cdv_stat_t stat;
	logic      in_ready;

	// input item numbers gathered into an array
	ball_t in_ball  [MAX_TICKET];
	ball_t out_ball [MAX_TICKET];

	assign in_ball[0] = in_ch.ball_1;
	assign in_ball[1] = in_ch.ball_2;
	assign in_ball[2] = in_ch.ball_3;
	assign in_ball[3] = in_ch.ball_4;
	assign in_ball[4] = in_ch.ball_5;
	assign in_ball[5] = in_ch.ball_6;
	assign in_ball[6] = in_ch.ball_7;

	// ready only while idle and after the clearing pass
	assign in_ch.ready = in_ready;

	cdv_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_cmd   (in_ch.cmd),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	cdv_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_cmd      (in_ch.cmd),
		.in_ball     (in_ball),
		.cmd         (cmd),
		.stat        (stat),
		.out_ready   (out_ch.ready),
		.out_valid   (out_ch.valid),
		.out_kind    (out_ch.kind),
		.out_status  (out_ch.status),
		.out_ball    (out_ball),
		.out_losing  (out_ch.losing_count),
		.out_winning (out_ch.winning_count),
		.out_last    (out_ch.last)
	);

	// reported subset numbers back onto the result channel
	assign out_ch.out_ball_1 = out_ball[0];
	assign out_ch.out_ball_2 = out_ball[1];
	assign out_ch.out_ball_3 = out_ball[2];
	assign out_ch.out_ball_4 = out_ball[3];
	assign out_ch.out_ball_5 = out_ball[4];
	assign out_ch.out_ball_6 = out_ball[5];
	assign out_ch.out_ball_7 = out_ball[6];

endmodule
